>>> rtl/bsas_pkg.sv
// bsas_pkg: shared codes, constants and cmd/meta structs for the breath sensor sequencer.
// No dependencies; imported by bsas_ctrl, bsas_dp and the top level.
package bsas_pkg;

    // input event kinds (tuser)
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_XFER  = 3'd1;
    localparam logic [2:0] MODE_START = 3'd2;
    localparam logic [2:0] MODE_STOP  = 3'd3;
    localparam logic [2:0] MODE_CLEAR = 3'd4;

    // sequence phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_REQ  = 2'd1;
    localparam logic [1:0] PH_FLOW = 2'd2;
    localparam logic [1:0] PH_PRES = 2'd3;

    // bus actions
    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_READ_PRES = 2'd1;
    localparam logic [1:0] ACT_READ_FLOW = 2'd2;
    localparam logic [1:0] ACT_SEND_REQ  = 2'd3;

    localparam logic [15:0] PERIOD_RESET = 16'd500;
    localparam logic [7:0]  BYTE_ALL_ONES = 8'hFF;

    // pressure: q = round(4499648*a + 1638375) / 3276750 with a = |raw14 - 1638|
    localparam logic [13:0] PRES_OFS = 14'd1638;
    localparam logic [22:0] PRES_K   = 23'd4499648;
    localparam logic [21:0] PRES_B   = 22'd1638375;
    localparam logic [21:0] PRES_D   = 22'd3276750;
    localparam logic [17:0] PRES_M   = 18'd20971;     // floor(2^36 / PRES_D)

    // flow: q = (512*a + 105) / 210 with a = |raw16|
    localparam logic [22:0] FLOW_K   = 23'd512;
    localparam logic [21:0] FLOW_B   = 22'd105;
    localparam logic [21:0] FLOW_D   = 22'd210;
    localparam logic [17:0] FLOW_M   = 18'd159783;    // floor(2^25 / FLOW_D)

    // volume: |acc| >> 10, then / 15 with saturation at 2^31
    localparam logic [34:0] VOL_LIM  = 35'd32212254720; // 15 * 2^31
    localparam logic [31:0] VOL_M    = 32'd2290649224;  // floor(2^35 / 15)
    localparam logic [35:0] VOL_DEN  = 36'd15;
    localparam logic [31:0] VOL_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] VOL_MIN  = 32'h8000_0000;

    localparam int IN_W  = 64;
    localparam int OUT_W = 88;

    typedef struct packed {
        logic load_pres;
        logic load_flow;
        logic clr;
        logic mk;
        logic mm;
        logic md;
        logic fix;
        logic mi;
        logic acc;
        logic vabs;
        logic vmul;
        logic vfix;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       sample;
        logic       led;
        logic [1:0] phase;
    } t_meta;

endpackage

>>> rtl/bsas_dp.sv
// bsas_dp: datapath for pressure/flow scaling, volume integration and volume readout.
// Steps are enabled one at a time by bsas_ctrl through t_cmd; uses bsas_pkg.
module bsas_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsas_pkg::t_cmd      i_cmd,
    input  logic [7:0]          i_b0,
    input  logic [7:0]          i_b1,
    input  logic [31:0]         i_now,
    output logic signed [15:0]  o_pres,
    output logic signed [17:0]  o_flow,
    output logic signed [31:0]  o_vol,
    output logic [15:0]         o_intv
);
    import bsas_pkg::*;

    logic               r_kind;     // 1: flow, 0: pressure
    logic               r_neg;
    logic [15:0]        r_mag;
    logic [35:0]        r_x;
    logic [16:0]        r_q0;
    logic [35:0]        r_t;
    logic signed [15:0] r_pres;
    logic signed [17:0] r_flow;
    logic [31:0]        r_last;
    logic [15:0]        r_intv;
    logic signed [34:0] r_dv;
    logic signed [63:0] r_acc;
    logic [34:0]        r_vm;
    logic               r_vneg;
    logic               r_vsat;
    logic [31:0]        r_vq0;
    logic signed [31:0] r_vol;

    logic [13:0]        w_raw14;
    logic [15:0]        w_raw16;
    logic [22:0]        w_k;
    logic [21:0]        w_b;
    logic [21:0]        w_d;
    logic [17:0]        w_m;
    logic [38:0]        w_mk;
    logic [53:0]        w_mm;
    logic [38:0]        w_md;
    logic [35:0]        w_r;
    logic [16:0]        w_q;
    logic [17:0]        w_res;
    logic signed [16:0] w_iv;
    logic signed [64:0] w_sum;
    logic [63:0]        w_abs;
    logic [53:0]        w_vmag;
    logic [66:0]        w_vprod;
    logic [35:0]        w_v15;
    logic [35:0]        w_vr;
    logic [31:0]        w_vq;

    always_comb begin
        w_raw14 = {i_b0[5:0], i_b1};
        w_raw16 = {i_b0, i_b1};
        w_k     = r_kind ? FLOW_K : PRES_K;
        w_b     = r_kind ? FLOW_B : PRES_B;
        w_d     = r_kind ? FLOW_D : PRES_D;
        w_m     = r_kind ? FLOW_M : PRES_M;
        w_mk    = 39'(r_mag) * 39'(w_k);
        w_mm    = 54'(r_x) * 54'(w_m);
        w_md    = 39'(r_q0) * 39'(w_d);
        w_r     = r_x - r_t;
        w_q     = r_q0 + 17'(w_r >= 36'(w_d));
        w_res   = r_neg ? (18'd0 - {1'b0, w_q}) : {1'b0, w_q};
        w_iv    = $signed({1'b0, r_intv});
        w_sum   = {r_acc[63], r_acc} + {{30{r_dv[34]}}, r_dv};
        w_abs   = r_acc[63] ? (~r_acc + 64'd1) : r_acc;
        w_vmag  = w_abs[63:10];
        w_vprod = 67'(r_vm) * 67'(VOL_M);
        w_v15   = {r_vq0, 4'b0} - {4'b0, r_vq0};
        w_vr    = {1'b0, r_vm} - w_v15;
        w_vq    = r_vq0 + 32'(w_vr >= VOL_DEN);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pres) begin
            r_kind <= 1'b0;
            r_neg  <= w_raw14 < PRES_OFS;
            r_mag  <= 16'((w_raw14 < PRES_OFS) ? (PRES_OFS - w_raw14) : (w_raw14 - PRES_OFS));
        end else if (i_cmd.load_flow) begin
            r_kind <= 1'b1;
            r_neg  <= !w_raw16[15] && (w_raw16 != 16'd0);
            r_mag  <= w_raw16[15] ? (~w_raw16 + 16'd1) : w_raw16;
        end
        if (i_cmd.mk) begin
            r_x <= w_mk[35:0] + 36'(w_b);
        end
        if (i_cmd.mm) begin
            r_q0 <= r_kind ? w_mm[41:25] : w_mm[52:36];
        end
        if (i_cmd.md) begin
            r_t <= w_md[35:0];
        end
        if (i_cmd.mi) begin
            r_dv <= 35'(r_flow) * 35'(w_iv);
        end
        if (i_cmd.vabs) begin
            r_vm   <= w_vmag[34:0];
            r_vneg <= r_acc[63];
            r_vsat <= w_vmag >= 54'(VOL_LIM);
        end
        if (i_cmd.vmul) begin
            r_vq0 <= w_vprod[66:35];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pres <= '0;
            r_flow <= '0;
            r_acc  <= '0;
            r_last <= '0;
            r_intv <= '0;
            r_vol  <= '0;
        end else begin
            if (i_cmd.load_flow) begin
                r_intv <= i_now[15:0] - r_last[15:0];
                r_last <= i_now;
            end
            if (i_cmd.fix) begin
                if (r_kind) begin
                    r_flow <= $signed(w_res);
                end else begin
                    r_pres <= $signed(w_res[15:0]);
                end
            end
            if (i_cmd.clr) begin
                r_acc <= '0;
                r_vol <= '0;
            end else begin
                if (i_cmd.acc) begin
                    if (w_sum[64] != w_sum[63]) begin
                        r_acc <= w_sum[64] ? $signed({1'b1, 63'd0}) : $signed({1'b0, {63{1'b1}}});
                    end else begin
                        r_acc <= w_sum[63:0];
                    end
                end
                if (i_cmd.vfix) begin
                    if (r_vsat) begin
                        r_vol <= r_vneg ? VOL_MIN : VOL_MAX;
                    end else begin
                        r_vol <= r_vneg ? (32'd0 - w_vq) : w_vq;
                    end
                end
            end
        end
    end

    assign o_pres = r_pres;
    assign o_flow = r_flow;
    assign o_vol  = r_vol;
    assign o_intv = r_intv;

endmodule

>>> rtl/bsas_ctrl.sv
// bsas_ctrl: sequencer state, heartbeat counter and step controller for bsas_dp.
// Uses bsas_pkg for codes and the t_cmd / t_meta structs.
module bsas_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [2:0]          i_mode,
    input  logic                i_err,
    input  logic [7:0]          i_b0,
    input  logic [7:0]          i_b1,
    input  logic [7:0]          i_b2,
    input  logic                i_cfg_valid,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_out_free,
    output logic                o_ready,
    output logic                o_emit,
    output bsas_pkg::t_cmd      o_cmd,
    output bsas_pkg::t_meta     o_meta
);
    import bsas_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MK   = 4'd1;
    localparam logic [3:0] S_MM   = 4'd2;
    localparam logic [3:0] S_MD   = 4'd3;
    localparam logic [3:0] S_FIX  = 4'd4;
    localparam logic [3:0] S_MI   = 4'd5;
    localparam logic [3:0] S_ACC  = 4'd6;
    localparam logic [3:0] S_VABS = 4'd7;
    localparam logic [3:0] S_VMUL = 4'd8;
    localparam logic [3:0] S_VFIX = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]  r_state, n_state;
    logic [1:0]  r_phase, n_phase;
    logic        r_running, n_running;
    logic [15:0] r_tick, n_tick;
    logic [15:0] r_period;
    logic        r_flow_kind, n_flow_kind;
    t_meta       r_meta, n_meta;
    logic [15:0] w_tick_inc;

    assign w_tick_inc = r_tick + 16'd1;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_running   = r_running;
        n_tick      = r_tick;
        n_flow_kind = r_flow_kind;
        n_meta      = r_meta;
        o_cmd       = '0;
        o_emit      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state       = S_OUT;
                    n_meta.action = ACT_NONE;
                    n_meta.sample = 1'b0;
                    n_meta.led    = 1'b0;
                    case (i_mode)
                        MODE_TICK: begin
                            if (r_running && r_phase == PH_IDLE) begin
                                n_phase       = PH_PRES;
                                n_meta.action = ACT_READ_PRES;
                                if (w_tick_inc == r_period) begin
                                    n_meta.led = 1'b1;
                                    n_tick     = '0;
                                end else begin
                                    n_tick = w_tick_inc;
                                end
                            end
                        end
                        MODE_XFER: begin
                            case (r_phase)
                                PH_PRES: begin
                                    n_phase       = PH_FLOW;
                                    n_meta.action = ACT_READ_FLOW;
                                    if (!i_err && i_b0[7:6] == 2'd0) begin
                                        o_cmd.load_pres = 1'b1;
                                        n_flow_kind     = 1'b0;
                                        n_state         = S_MK;
                                    end
                                end
                                PH_REQ: begin
                                    n_phase = PH_IDLE;
                                end
                                PH_FLOW: begin
                                    if (i_err || (i_b0 == BYTE_ALL_ONES && i_b1 == BYTE_ALL_ONES
                                                  && i_b2 == BYTE_ALL_ONES)) begin
                                        n_phase = PH_IDLE;
                                    end else begin
                                        o_cmd.load_flow = 1'b1;
                                        n_flow_kind     = 1'b1;
                                        n_phase         = PH_REQ;
                                        n_meta.action   = ACT_SEND_REQ;
                                        n_meta.sample   = 1'b1;
                                        n_state         = S_MK;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        MODE_START: begin
                            n_running     = 1'b1;
                            n_phase       = PH_REQ;
                            n_meta.action = ACT_SEND_REQ;
                        end
                        MODE_STOP: begin
                            n_running = 1'b0;
                        end
                        MODE_CLEAR: begin
                            o_cmd.clr = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    n_meta.phase = n_phase;
                end
            end
            S_MK: begin
                o_cmd.mk = 1'b1;
                n_state  = S_MM;
            end
            S_MM: begin
                o_cmd.mm = 1'b1;
                n_state  = S_MD;
            end
            S_MD: begin
                o_cmd.md = 1'b1;
                n_state  = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = r_flow_kind ? S_MI : S_OUT;
            end
            S_MI: begin
                o_cmd.mi = 1'b1;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_VABS;
            end
            S_VABS: begin
                o_cmd.vabs = 1'b1;
                n_state    = S_VMUL;
            end
            S_VMUL: begin
                o_cmd.vmul = 1'b1;
                n_state    = S_VFIX;
            end
            S_VFIX: begin
                o_cmd.vfix = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_running   <= 1'b0;
            r_tick      <= '0;
            r_period    <= PERIOD_RESET;
            r_flow_kind <= 1'b0;
            r_meta      <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_running   <= n_running;
            r_tick      <= n_tick;
            r_flow_kind <= n_flow_kind;
            r_meta      <= n_meta;
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_meta  = r_meta;

endmodule

>>> rtl/breath_sensor_acquisition_sequencer.sv
// breath_sensor_acquisition_sequencer: top level, stream ports and output register.
// Instantiates bsas_ctrl and bsas_dp; uses bsas_pkg.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata[56:0], tuser[2:0] = mode
//  m_axis    out  m_axis_tvalid/tready       tdata[86:0], tuser[0] = flow_sample_new
//  cfg       in   i_cfg_valid/o_cfg_ready    i_cfg_data = led_toggle_period
//
//  Events with no arithmetic go straight to the output step; a pressure reply
//  runs MK, MM, MD and FIX, and a flow reply then adds MI, ACC, VABS, VMUL, VFIX.
//  An item is taken only while the controller is idle; one result may wait in
//  the output register while the next item is processed.
//  Reset: synchronous, active low; period to 500, control and result state cleared.
//  A stalled output holds the controller in its final step until the register frees.
module breath_sensor_acquisition_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] bus_error, [8:1] rx_byte_first, [16:9] rx_byte_second,
    // [24:17] rx_byte_third, [56:25] now_us, rest zero
    input  logic [63:0] s_axis_tdata,
    // [2:0] mode
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] bus_action, [17:2] pressure_q8, [35:18] flow_q8, [67:36] volume_ul,
    // [83:68] flow_interval_us, [84] led_toggle, [86:85] phase_now, [87] zero
    output logic [87:0] m_axis_tdata,
    // [0] flow_sample_new
    output logic        m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import bsas_pkg::*;

    t_cmd               w_cmd;
    t_meta              w_meta;
    logic               w_emit;
    logic               w_out_free;
    logic               w_ready;
    logic signed [15:0] w_pres;
    logic signed [17:0] w_flow;
    logic signed [31:0] w_vol;
    logic [15:0]        w_intv;

    logic               r_m_valid;
    logic [OUT_W-1:0]   r_m_data;
    logic               r_m_user;

    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = w_ready;
    assign o_cfg_ready   = 1'b1;

    bsas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_mode      (s_axis_tuser),
        .i_err       (s_axis_tdata[0]),
        .i_b0        (s_axis_tdata[8:1]),
        .i_b1        (s_axis_tdata[16:9]),
        .i_b2        (s_axis_tdata[24:17]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_free  (w_out_free),
        .o_ready     (w_ready),
        .o_emit      (w_emit),
        .o_cmd       (w_cmd),
        .o_meta      (w_meta)
    );

    bsas_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_b0    (s_axis_tdata[8:1]),
        .i_b1    (s_axis_tdata[16:9]),
        .i_now   (s_axis_tdata[56:25]),
        .o_pres  (w_pres),
        .o_flow  (w_flow),
        .o_vol   (w_vol),
        .o_intv  (w_intv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_emit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_m_data <= {1'b0, w_meta.phase, w_meta.led,
                         w_meta.sample ? w_intv : 16'd0,
                         w_vol, w_flow, w_pres, w_meta.action};
            r_m_user <= w_meta.sample;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in consecutive cycles");

    a_sample_sends_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[1:0] == ACT_SEND_REQ && m_axis_tdata[86:85] == PH_REQ)
        else $error("flow sample without flow request");

    a_interval_only_with_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[83:68] == 16'd0)
        else $error("interval reported without a flow sample");

    a_led_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[84] |->
            m_axis_tdata[1:0] == ACT_READ_PRES && m_axis_tdata[86:85] == PH_PRES)
        else $error("heartbeat toggle outside a pressure read start");
`endif

endmodule

>>> bench/tb_top.sv
// tb_top: self-checking bench for breath_sensor_acquisition_sequencer.
// Drives event transfers and period writes, predicts every result in-bench and
// checks each output transfer in order. Depends on bsas_pkg and the top level RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bsas_pkg::*;

    localparam int     STALL_LIMIT  = 2000;
    localparam int     REPORT_LIMIT = 10;
    localparam int     RUN_SAMPLES  = 8;
    localparam logic [2:0] MODE_SPARE = 3'd7;
    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN = -ACC_MAX - 64'sd1;
    localparam longint UL_DIV  = 64'sd15360;
    localparam longint UL_MAX  = 64'sd2147483647;
    localparam longint UL_MIN  = -64'sd2147483648;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] pressure;
        logic [17:0] flow;
        logic [31:0] volume;
        logic        sample;
        logic [15:0] interval;
        logic        led;
        logic [1:0]  phase;
    } t_seq_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    // sequencer model state
    logic [1:0]  st_phase          = PH_IDLE;
    logic        st_running        = 1'b0;
    logic [15:0] st_ticks          = '0;
    longint      st_pressure       = 0;
    longint      st_flow           = 0;
    longint      st_volume_acc     = 0;
    logic [31:0] st_last_sample_us = '0;
    logic [15:0] led_period        = PERIOD_RESET;

    t_seq_result expected_results[$];
    t_seq_result observed;
    t_seq_result wanted;
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          items_sent     = 0;
    int          src_gap_pct    = 25;
    int          sink_stall_pct = 25;
    logic [31:0] clock_us       = '0;

    breath_sensor_acquisition_sequencer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // nearest, ties away from zero, den > 0
    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0) begin
            return (2 * num + den) / (2 * den);
        end
        return -((-2 * num + den) / (2 * den));
    endfunction

    function automatic t_seq_result advance_sequencer(input logic [2:0] mode, input logic err,
                                                      input logic [7:0] b0, input logic [7:0] b1,
                                                      input logic [7:0] b2, input logic [31:0] now);
        t_seq_result r;
        longint      raw;
        longint      span;
        longint      delta;
        longint      vol;
        logic [15:0] word;
        logic [15:0] gap;
        r = '0;
        word = {b0, b1};
        case (mode)
            MODE_TICK: begin
                if (st_running && st_phase == PH_IDLE) begin
                    st_phase = PH_PRES;
                    r.action = ACT_READ_PRES;
                    st_ticks = st_ticks + 16'd1;
                    if (st_ticks == led_period) begin
                        r.led = 1'b1;
                        st_ticks = '0;
                    end
                end
            end
            MODE_XFER: begin
                if (st_phase == PH_PRES) begin
                    if (!err && b0[7:6] == 2'b00) begin
                        raw = longint'(word[13:0]);
                        st_pressure = round_div(64'sd17998592 * (raw - 64'sd1638),
                                                64'sd13107000);
                    end
                    st_phase = PH_FLOW;
                    r.action = ACT_READ_FLOW;
                end else if (st_phase == PH_REQ) begin
                    st_phase = PH_IDLE;
                end else if (st_phase == PH_FLOW) begin
                    if (err || {b0, b1, b2} == {3{BYTE_ALL_ONES}}) begin
                        st_phase = PH_IDLE;
                    end else begin
                        raw = longint'($signed(word));
                        st_flow = round_div(-raw * 64'sd256, 64'sd105);
                        gap = now[15:0] - st_last_sample_us[15:0];
                        st_last_sample_us = now;
                        span = longint'(gap);
                        delta = st_flow * span;
                        if (delta > 0 && st_volume_acc > ACC_MAX - delta) begin
                            st_volume_acc = ACC_MAX;
                        end else if (delta < 0 && st_volume_acc < ACC_MIN - delta) begin
                            st_volume_acc = ACC_MIN;
                        end else begin
                            st_volume_acc = st_volume_acc + delta;
                        end
                        r.sample = 1'b1;
                        r.interval = gap;
                        st_phase = PH_REQ;
                        r.action = ACT_SEND_REQ;
                    end
                end
            end
            MODE_START: begin
                st_running = 1'b1;
                st_phase = PH_REQ;
                r.action = ACT_SEND_REQ;
            end
            MODE_STOP: begin
                st_running = 1'b0;
            end
            MODE_CLEAR: begin
                st_volume_acc = 0;
            end
            default: begin
            end
        endcase
        vol = st_volume_acc / UL_DIV;
        if (vol > UL_MAX) vol = UL_MAX;
        if (vol < UL_MIN) vol = UL_MIN;
        r.pressure = st_pressure[15:0];
        r.flow = st_flow[17:0];
        r.volume = vol[31:0];
        r.phase = st_phase;
        return r;
    endfunction

    function automatic string show(input t_seq_result r);
        return $sformatf("act=%0d p=%0d f=%0d v=%0d new=%0b iv=%0d led=%0b ph=%0d",
                         r.action, $signed(r.pressure), $signed(r.flow), $signed(r.volume),
                         r.sample, r.interval, r.led, r.phase);
    endfunction

    // one event transfer; entered and left at a falling edge, tvalid left high
    task automatic send_event(input logic [2:0] mode, input logic err, input logic [7:0] b0,
                              input logic [7:0] b1, input logic [7:0] b2,
                              input logic [31:0] now);
        if (src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tuser  = mode;
        s_axis_tdata  = {7'd0, now, b2, b1, b0, err};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(advance_sequencer(mode, err, b0, b1, b2, now));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_led_period(input logic [15:0] value);
        drain_results();
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        led_period = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // walk back to idle with failed transfers
    task automatic finish_sequence();
        while (st_phase != PH_IDLE) begin
            send_event(MODE_XFER, 1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), $urandom());
        end
    endtask

    task automatic lone_tick();
        send_event(MODE_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom());
        finish_sequence();
    endtask

    // start if stopped, then tick, pressure reply, flow reply, request completion
    task automatic breath_cycle(input logic p_err, input logic [7:0] p0, input logic [7:0] p1,
                                input logic f_err, input logic [7:0] f0, input logic [7:0] f1,
                                input logic [7:0] f2, input logic [31:0] flow_now);
        if (!st_running) begin
            send_event(MODE_START, 1'b0, 8'd0, 8'd0, 8'd0, $urandom());
        end
        finish_sequence();
        send_event(MODE_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom());
        send_event(MODE_XFER, p_err, p0, p1, 8'($urandom_range(0, 255)), $urandom());
        send_event(MODE_XFER, f_err, f0, f1, f2, flow_now);
        finish_sequence();
    endtask

    task automatic test_inactive_events();
        send_event(MODE_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
        send_event(MODE_XFER, 1'b0, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_event(MODE_STOP, 1'b1, 8'hA5, 8'h5A, 8'hC3, 32'h1234_5678);
        send_event(MODE_CLEAR, 1'b0, 8'h00, 8'h00, 8'h00, 32'h0);
        send_event(MODE_SPARE, 1'b1, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_heartbeat();
        write_led_period(16'd1);
        send_event(MODE_START, 1'b0, 8'd0, 8'd0, 8'd0, 32'd0);
        finish_sequence();
        lone_tick();
        write_led_period(16'd0);
        lone_tick();
        write_led_period(16'hFFFF);
        lone_tick();
    endtask

    task automatic test_sequence_corners();
        // full-scale negative flow over the longest interval, lowest pressure code
        breath_cycle(1'b0, 8'h00, 8'h00, 1'b0, 8'h80, 8'h00, 8'h00,
                     st_last_sample_us + 32'h0000_FFFF);
        // highest pressure code, full-scale positive flow, zero interval
        breath_cycle(1'b0, 8'h3F, 8'hFF, 1'b0, 8'h7F, 8'hFF, 8'hFF, st_last_sample_us);
        // status bits set keep pressure; all-ones flow reply drops the sample
        breath_cycle(1'b0, 8'hC0, 8'h12, 1'b0, 8'hFF, 8'hFF, 8'hFF, $urandom());
        // bus errors on both replies
        breath_cycle(1'b1, 8'h06, 8'h66, 1'b1, 8'h11, 8'h22, 8'h33, $urandom());
        // pressure at offset, flow of minus one count
        breath_cycle(1'b0, 8'h06, 8'h66, 1'b0, 8'hFF, 8'hFF, 8'h00,
                     st_last_sample_us + 32'd1000);
        // stop and start in the middle of a sequence
        send_event(MODE_TICK, 1'b0, 8'd0, 8'd0, 8'd0, $urandom());
        send_event(MODE_STOP, 1'b0, 8'd0, 8'd0, 8'd0, $urandom());
        send_event(MODE_XFER, 1'b0, 8'h20, 8'h00, 8'h00, $urandom());
        send_event(MODE_START, 1'b0, 8'd0, 8'd0, 8'd0, $urandom());
        send_event(MODE_XFER, 1'b0, 8'd0, 8'd0, 8'd0, $urandom());
        send_event(MODE_STOP, 1'b0, 8'd0, 8'd0, 8'd0, $urandom());
        send_event(MODE_TICK, 1'b0, 8'd0, 8'd0, 8'd0, $urandom());
        send_event(MODE_CLEAR, 1'b0, 8'd0, 8'd0, 8'd0, $urandom());
    endtask

    task automatic test_random_traffic();
        int         stop_at;
        int         kind;
        logic [7:0] f0;
        logic [7:0] f1;
        logic [7:0] f2;
        logic [7:0] p0;
        stop_at = items_sent + 300;
        write_led_period(st_ticks + 16'd2);
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 11) == 0) begin
                src_gap_pct    = 25 * $urandom_range(0, 2);
                sink_stall_pct = 25 * $urandom_range(0, 2);
            end
            if ($urandom_range(0, 29) == 0) begin
                write_led_period(st_ticks + 16'($urandom_range(1, 5)));
            end
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 3) == 0) begin
                    clock_us = clock_us + $urandom();
                end else begin
                    clock_us = clock_us + $urandom_range(0, 70000);
                end
                kind = $urandom_range(0, 9);
                f0 = 8'($urandom_range(0, 255));
                f1 = 8'($urandom_range(0, 255));
                f2 = 8'($urandom_range(0, 255));
                if (kind == 1) begin
                    {f0, f1, f2} = {3{BYTE_ALL_ONES}};
                end else if (kind == 2) begin
                    {f0, f1} = {2{BYTE_ALL_ONES}};
                end
                if ($urandom_range(0, 5) == 0) begin
                    p0 = 8'($urandom_range(0, 255));
                end else begin
                    p0 = 8'($urandom_range(0, 63));
                end
                breath_cycle($urandom_range(0, 7) == 0, p0, 8'($urandom_range(0, 255)),
                             kind == 0, f0, f1, f2, clock_us);
            end else begin
                send_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), $urandom());
            end
        end
    endtask

    // runs at full-scale flow over the longest interval, both signs, no idling
    task automatic test_full_scale_flow();
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        send_event(MODE_CLEAR, 1'b0, 8'd0, 8'd0, 8'd0, $urandom());
        repeat (RUN_SAMPLES) begin
            breath_cycle(1'b0, 8'h20, 8'h00, 1'b0, 8'h80, 8'h00, 8'h00,
                         st_last_sample_us + 32'h0000_FFFF);
        end
        send_event(MODE_CLEAR, 1'b0, 8'd0, 8'd0, 8'd0, $urandom());
        repeat (RUN_SAMPLES) begin
            breath_cycle(1'b0, 8'h20, 8'h00, 1'b0, 8'h7F, 8'hFF, 8'h00,
                         st_last_sample_us + 32'h0000_FFFF);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            observed.action   = m_axis_tdata[1:0];
            observed.pressure = m_axis_tdata[17:2];
            observed.flow     = m_axis_tdata[35:18];
            observed.volume   = m_axis_tdata[67:36];
            observed.interval = m_axis_tdata[83:68];
            observed.led      = m_axis_tdata[84];
            observed.phase    = m_axis_tdata[86:85];
            observed.sample   = m_axis_tuser;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected result: %s", show(observed));
                end
            end else begin
                wanted = expected_results.pop_front();
                if (observed !== wanted) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("result mismatch\n  expected %s\n  actual   %s",
                                 show(wanted), show(observed));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_stall_pct != 0 && $urandom_range(1, 100) <= sink_stall_pct) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_TICK;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_inactive_events();
        test_heartbeat();
        test_sequence_corners();
        test_random_traffic();
        test_full_scale_flow();
        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/bsas_pkg.sv
rtl/bsas_dp.sv
rtl/bsas_ctrl.sv
rtl/breath_sensor_acquisition_sequencer.sv
bench/tb_top.sv
